/* sv/fta_pkg.sv */
// Shared types and constants for the frame time averager.
// Used by the delta cells, the elapsed clock, the advance pipeline and the top level.
package fta_pkg;

    // Item kinds carried in the low bits of the input tuser.
    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_RESUME  = 2'd2
    } t_kind;

    // Delta loaded into every ring cell on reset and on restart.
    localparam int RESTART_DELTA = 10;

    // Last value of the seconds and minutes counters before they wrap.
    localparam logic [5:0] CLOCK_LAST = 6'd59;

    // Width of 30 * average * gain, and the largest frame advance.
    localparam int          PROD_W  = 29;
    localparam logic [18:0] ADV_MAX = 19'h7FFFF;

    // Counter values reported with each result item.
    typedef struct packed {
        logic [7:0] fps;
        logic [7:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
    } t_report;

endpackage

/* sv/frame_time_averager_unit.sv */
// Frame time averager top level: delta cell chain, running sum, clock and result pipeline.
// Depends on fta_pkg, fta_cell, fta_clock and fta_advance.
//
// Usage:
//   The input stream carries one item per frame event. tuser holds the kind
//   (tick, restart, resume) and the frozen flag; tdata holds the 8-bit
//   millisecond clock sample. Every accepted item gives exactly one result
//   item on the output stream with the average frame time, the frame
//   advance in Q11.8, the latched frames per second and the elapsed time.
//   The configuration channel writes the Q8.8 speed gain; it is always ready.
//   The user must write it only while the block is idle; the block itself does not enforce this.
//   Throughput is one item per cycle while the receiver does not stall. A result
//   passes through each register of the result pipeline in turn after its item
//   is accepted (input, average by reciprocal multiply, gain multiply, scale by
//   30, reciprocal multiply for the division by the tick count, output).
//   The delta chain, sum and clock update in the accepting cycle, so the next
//   item may follow at once.
//   When the receiver stalls, the whole result pipeline holds and tready
//   of the input falls until the output register is taken.
//   Reset fills every delta cell with ten at once, clears the clock, the
//   frame counts and the pipeline, and sets the gain to 1.0.
module frame_time_averager_unit import fta_pkg::*; #(
    parameter int RING_DEPTH       = 16,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] clock_sample
    input  logic [2:0]  i_s_axis_tuser,  // [1:0] kind, [2] frozen
    // Result items.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // [7:0] average_frame_ms, [26:8] frame_advance,
                                         // [34:27] frames_per_second, [42:35] elapsed_hours,
                                         // [48:43] elapsed_minutes, [54:49] elapsed_seconds,
                                         // [64:55] elapsed_millis, [71:65] zero
    // Speed gain register.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int SUM_W = 8 + $clog2(RING_DEPTH);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(RESTART_DELTA * RING_DEPTH);

    t_kind            kind;
    logic             frozen, accept, in_ready;
    logic             tick, restart, load_prev, use_avg;
    logic [7:0]       delta;
    logic [SUM_W-1:0] n_sum, sum_out;
    logic [7:0]       chain [RING_DEPTH];
    logic [7:0]       r_prev;
    logic [SUM_W-1:0] r_sum;
    logic             r_avg_valid;
    logic [15:0]      r_turbo;
    t_report          report, out_report;
    logic [7:0]       out_avg;
    logic [18:0]      out_adv;

    assign kind   = t_kind'(i_s_axis_tuser[1:0]);
    assign frozen = i_s_axis_tuser[2];
    assign accept = i_s_axis_tvalid && in_ready;
    assign delta  = i_s_axis_tdata - r_prev;

    // The oldest delta leaves the tail of the chain as the new one enters.
    assign n_sum = r_sum - {{(SUM_W - 8){1'b0}}, chain[RING_DEPTH-1]}
                         + {{(SUM_W - 8){1'b0}}, delta};

    // Decode of the item kind.
    always_comb begin
        tick      = 1'b0;
        restart   = 1'b0;
        load_prev = 1'b0;
        use_avg   = r_avg_valid;
        sum_out   = r_sum;
        case (kind)
            KIND_TICK: begin
                if (frozen) begin
                    use_avg = 1'b0;
                end else begin
                    tick      = accept;
                    load_prev = accept;
                    use_avg   = 1'b1;
                    sum_out   = n_sum;
                end
            end
            KIND_RESTART: begin
                restart   = accept;
                load_prev = accept;
                use_avg   = 1'b0;
            end
            KIND_RESUME: begin
                load_prev = accept;
            end
            default: begin
                load_prev = 1'b0;
            end
        endcase
    end

    // Chain of delta cells.
    for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            fta_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (tick),
                .i_load  (restart),
                .i_data  (delta),
                .o_data  (chain[g])
            );
        end else begin : g_body
            fta_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (tick),
                .i_load  (restart),
                .i_data  (chain[g-1]),
                .o_data  (chain[g])
            );
        end
    end

    // Running sum, reference sample, average state and speed gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_sum       <= SUM_RESET;
            r_avg_valid <= 1'b0;
            r_turbo     <= 16'd256;
        end else begin
            if (load_prev) begin
                r_prev <= i_s_axis_tdata;
            end
            if (restart) begin
                r_sum       <= SUM_RESET;
                r_avg_valid <= 1'b0;
            end else if (tick) begin
                r_sum       <= n_sum;
                r_avg_valid <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_turbo <= i_cfg_data;
            end
        end
    end

    fta_clock #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_clock (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_restart (restart),
        .i_delta   (delta),
        .o_next    (report)
    );

    fta_advance #(
        .RING_DEPTH       (RING_DEPTH),
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .SUM_W            (SUM_W)
    ) u_advance (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .o_ready   (in_ready),
        .i_use_avg (use_avg),
        .i_sum     (sum_out),
        .i_turbo   (r_turbo),
        .i_report  (report),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_avg     (out_avg),
        .o_adv     (out_adv),
        .o_report  (out_report)
    );

    assign o_s_axis_tready = in_ready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tdata  = {7'b0, out_report.millis, out_report.seconds,
                              out_report.minutes, out_report.hours, out_report.fps,
                              out_adv, out_avg};

endmodule

/* sv/fta_cell.sv */
// One cell of the delta shift chain: holds one frame delta.
// Depends on fta_pkg for the restart delta.
module fta_cell import fta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_load,
    input  logic [7:0] i_data,
    output logic [7:0] o_data
);

    logic [7:0] r_delta;

    // Reset and restart refill the cell; a tick takes the delta at its input (the new delta at the head).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_load) begin
            r_delta <= 8'(RESTART_DELTA);
        end else if (i_shift) begin
            r_delta <= i_data;
        end
    end

    assign o_data = r_delta;

endmodule

/* sv/fta_clock.sv */
// Elapsed time counters, frame tally and latched frames per second.
// Depends on fta_pkg for the report struct and clock constants.
module fta_clock import fta_pkg::*; #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic       i_restart,
    input  logic [7:0] i_delta,
    output t_report    o_next
);

    // With a large tick count the millisecond counter stays below it;
    // otherwise it may grow and is kept as a full 32-bit word.
    localparam int MW = (TICKS_PER_SECOND >= 255) ? $clog2(TICKS_PER_SECOND + 255) : 32;
    localparam logic [MW-1:0] TPS_C = MW'(TICKS_PER_SECOND);

    logic [MW-1:0] r_millis, n_millis, millis_sum;
    logic [5:0]    r_sec, n_sec, r_min, n_min;
    logic [7:0]    r_hours, n_hours, r_tally, n_tally, r_fps, n_fps;
    logic [MW+9:0] millis_ext;

    // Next counter values for this item.
    always_comb begin
        millis_sum = r_millis + MW'(i_delta);
        n_millis   = r_millis;
        n_sec      = r_sec;
        n_min      = r_min;
        n_hours    = r_hours;
        n_tally    = r_tally;
        n_fps      = r_fps;
        if (i_restart) begin
            n_millis = '0;
            n_sec    = '0;
            n_min    = '0;
            n_hours  = '0;
        end else if (i_tick) begin
            if (millis_sum >= TPS_C) begin
                n_millis = millis_sum - TPS_C;
                n_fps    = r_tally;
                n_tally  = 8'd1;
                if (r_sec == CLOCK_LAST) begin
                    n_sec = '0;
                    if (r_min == CLOCK_LAST) begin
                        n_min   = '0;
                        n_hours = r_hours + 8'd1;
                    end else begin
                        n_min = r_min + 6'd1;
                    end
                end else begin
                    n_sec = r_sec + 6'd1;
                end
            end else begin
                n_millis = millis_sum;
                n_tally  = r_tally + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_millis <= '0;
            r_sec    <= '0;
            r_min    <= '0;
            r_hours  <= '0;
            r_tally  <= '0;
            r_fps    <= '0;
        end else begin
            r_millis <= n_millis;
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hours  <= n_hours;
            r_tally  <= n_tally;
            r_fps    <= n_fps;
        end
    end

    // The report shows the counters after this item's update.
    assign millis_ext     = {10'b0, n_millis};
    assign o_next.fps     = n_fps;
    assign o_next.hours   = n_hours;
    assign o_next.minutes = n_min;
    assign o_next.seconds = n_sec;
    assign o_next.millis  = millis_ext[9:0];

endmodule

/* sv/fta_advance.sv */
// Result pipeline: average from the delta sum, then the frame advance,
// with the output register. Depends on fta_pkg for the report struct.
module fta_advance import fta_pkg::*; #(
    parameter int RING_DEPTH       = 16,
    parameter int TICKS_PER_SECOND = 1000,
    parameter int SUM_W            = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_use_avg,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [15:0]      i_turbo,
    input  t_report          i_report,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_avg,
    output logic [18:0]      o_adv,
    output t_report          o_report
);

    // Exact division by a constant: multiply by the rounded-up reciprocal.
    localparam int AVG_S  = SUM_W + $clog2(RING_DEPTH);
    localparam int AVG_MW = SUM_W + 2;
    localparam logic [63:0] AVG_M64 =
        ((64'd1 << AVG_S) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [AVG_MW-1:0] AVG_M = AVG_M64[AVG_MW-1:0];
    localparam int AVG_PW = SUM_W + AVG_MW;

    localparam int ADV_S  = PROD_W + $clog2(TICKS_PER_SECOND);
    localparam int ADV_MW = PROD_W + 2;
    localparam logic [63:0] ADV_M64 =
        ((64'd1 << ADV_S) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
    localparam logic [ADV_MW-1:0] ADV_M = ADV_M64[ADV_MW-1:0];
    localparam int ADV_PW = PROD_W + ADV_MW;

    logic              en;
    logic              r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic              r_use1;
    logic [SUM_W-1:0]  r_sum1;
    logic [7:0]        r_avg2, r_avg3, r_avg4, r_avg5, r_avg_out;
    logic [23:0]       r_gain3;
    logic [PROD_W-1:0] r_prod4;
    logic [ADV_PW-1:0] r_scaled5;
    logic [18:0]       r_adv_out;
    t_report           r_rep1, r_rep2, r_rep3, r_rep4, r_rep5, r_rep_out;

    logic [AVG_PW-1:0] avg_prod, avg_shift;
    logic [7:0]        avg_val;
    logic [ADV_PW-1:0] adv_shift;
    logic [PROD_W-1:0] adv_quot;
    logic [18:0]       adv_val;

    // The whole pipeline holds while the output register waits.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // Average and frame advance arithmetic between the stages.
    always_comb begin
        avg_prod  = {AVG_MW'(0), r_sum1} * {SUM_W'(0), AVG_M};
        avg_shift = avg_prod >> AVG_S;
        avg_val   = r_use1 ? avg_shift[7:0] : 8'd0;
        adv_shift = r_scaled5 >> ADV_S;
        adv_quot  = adv_shift[PROD_W-1:0];
        adv_val   = (adv_quot > PROD_W'(ADV_MAX)) ? ADV_MAX : adv_quot[18:0];
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_use1    <= i_use_avg;
            r_sum1    <= i_sum;
            r_rep1    <= i_report;
            r_avg2    <= avg_val;
            r_rep2    <= r_rep1;
            r_avg3    <= r_avg2;
            r_gain3   <= {16'b0, r_avg2} * {8'b0, i_turbo};
            r_rep3    <= r_rep2;
            r_avg4    <= r_avg3;
            r_prod4   <= {r_gain3, 5'b0} - {4'b0, r_gain3, 1'b0};
            r_rep4    <= r_rep3;
            r_avg5    <= r_avg4;
            r_scaled5 <= {ADV_MW'(0), r_prod4} * {PROD_W'(0), ADV_M};
            r_rep5    <= r_rep4;
            r_avg_out <= r_avg5;
            r_adv_out <= adv_val;
            r_rep_out <= r_rep5;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_avg    = r_avg_out;
    assign o_adv    = r_adv_out;
    assign o_report = r_rep_out;

endmodule

/* sv/fta_checker.sv */
// Port-level checks for the frame time averager, bound to the top level.
// Depends only on the top level's ports.
module fta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata
);

    // A stalled result item stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result payload changed while stalled");

    // Reset empties the result pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result item valid after reset");

    // With the output register empty the block takes input items.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    // A zero average gives a zero frame advance.
    a_zero_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[7:0] == 8'd0) |-> (o_m_axis_tdata[26:8] == 19'd0))
        else $error("frame advance nonzero with zero average");

endmodule

bind frame_time_averager_unit fta_checker u_fta_checker (.*);
